>>> rtl/sirb_pkg.sv
// ----------------------------------------------------------------------------
// sirb_pkg: shared types and constants for the range-bound identifier parser
// Holds the character codes, the character class type and the parser state
// and result records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package sirb_pkg;

  // Character codes that the parser recognises.
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int unsigned VALUE_W = 64;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Saturating character count: two means "more than one".
  localparam logic [1:0] CHARS_MANY = 2'd2;

  // Class of the first character of an identifier.
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_DASH  = 2'd1,
    CLS_PLUS  = 2'd2
  } char_class_t;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic               after_dash;
    logic [VALUE_W-1:0] millis_acc;
    logic [VALUE_W-1:0] sequence_acc;
    logic               bad_seen;
    char_class_t        first_class;
    logic [1:0]         chars_seen;
    logic               seq_digit_seen;
  } parse_state_t;

  // One parsed identifier.
  typedef struct packed {
    logic [VALUE_W-1:0] millis_value;
    logic [VALUE_W-1:0] sequence_value;
    logic               id_valid;
  } parse_result_t;

endpackage

>>> rtl/sirb_step.sv
// ----------------------------------------------------------------------------
// sirb_step: one-character step of the identifier parser
// Purely combinational. Takes the current parser state and one character and
// returns the next state and, for the last character, the parsed result.
// ----------------------------------------------------------------------------
module sirb_step (
  input  sirb_pkg::parse_state_t  state_cur,
  input  logic [7:0]              char_byte,
  input  logic                    last_char,
  input  logic                    bound_is_start,
  output sirb_pkg::parse_state_t  state_nxt,
  output sirb_pkg::parse_result_t result
);
  import sirb_pkg::*;

  logic               is_dash;
  logic               is_plus;
  logic               is_digit;
  logic [VALUE_W-1:0] acc_sel;
  logic [VALUE_W-1:0] acc_prod;
  logic [VALUE_W-1:0] digit_val;
  parse_state_t       upd;

  // Classify the character.
  assign is_dash  = (char_byte == CHAR_DASH);
  assign is_plus  = (char_byte == CHAR_PLUS);
  assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);

  // The low nibble of an ASCII digit is its value.
  assign digit_val = {{(VALUE_W-4){1'b0}}, char_byte[3:0]};

  // Times ten as a shift-add on whichever part is being built, wrapping.
  assign acc_sel  = state_cur.after_dash ? state_cur.sequence_acc : state_cur.millis_acc;
  assign acc_prod = (acc_sel << 3) + (acc_sel << 1) + digit_val;

  // Fold the character into the state.
  always_comb begin
    upd = state_cur;
    if (state_cur.chars_seen == 2'd0) begin
      if (is_dash) begin
        upd.first_class = CLS_DASH;
      end else if (is_plus) begin
        upd.first_class = CLS_PLUS;
      end else begin
        upd.first_class = CLS_OTHER;
      end
    end
    if (is_dash) begin
      if (state_cur.after_dash || (state_cur.chars_seen == 2'd0)) begin
        upd.bad_seen = 1'b1;
      end
      upd.after_dash = 1'b1;
    end else if (is_digit) begin
      if (state_cur.after_dash) begin
        upd.sequence_acc   = acc_prod;
        upd.seq_digit_seen = 1'b1;
      end else begin
        upd.millis_acc = acc_prod;
      end
    end else begin
      upd.bad_seen = 1'b1;
    end
    if (state_cur.chars_seen != CHARS_MANY) begin
      upd.chars_seen = state_cur.chars_seen + 2'd1;
    end
  end

  // Judge the identifier as it stands after this character.
  always_comb begin
    result = '0;
    priority if ((upd.chars_seen == 2'd1) && (upd.first_class == CLS_DASH)) begin
      result.id_valid = bound_is_start;
    end else if ((upd.chars_seen == 2'd1) && (upd.first_class == CLS_PLUS)) begin
      result.id_valid = !bound_is_start;
      if (!bound_is_start) begin
        result.millis_value   = VALUE_MAX;
        result.sequence_value = VALUE_MAX;
      end
    end else if (upd.bad_seen) begin
      result.id_valid = 1'b0;
    end else if (upd.after_dash) begin
      result.id_valid = upd.seq_digit_seen;
      if (upd.seq_digit_seen) begin
        result.millis_value   = upd.millis_acc;
        result.sequence_value = upd.sequence_acc;
      end
    end else begin
      result.id_valid       = 1'b1;
      result.millis_value   = upd.millis_acc;
      result.sequence_value = bound_is_start ? '0 : VALUE_MAX;
    end
  end

  // The state starts afresh after the last character.
  assign state_nxt = last_char ? '0 : upd;

endmodule

>>> rtl/stream_id_range_bound_parser.sv
// ----------------------------------------------------------------------------
// stream_id_range_bound_parser: range-bound stream identifier parser
// Parses "<millis>-<seq>", "<millis>", "-" or "+" one character per beat.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one character per beat with a last mark and a
// start/end bound flag. Each beat is held in an input register; from there
// the step logic folds it into the parser state (one 64-bit multiply by
// ten as a shift-add) and, on the last character, loads the result register.
// The output channel gives one beat per identifier: millisecond part,
// sequence part and a valid flag; both parts read zero when invalid.
// A result passes from the input register through the step logic into the
// result register before it is presented on the output ports.
// Throughput: one character per cycle, set by the single step stage.
// A character without the last mark never waits on the output side. When the
// result register is full and stalled, a last character holds in the input
// register and in_stall rises until the result is taken.
// Reset clears the parser state and both valid flags; there is no start-up
// sweep and the first beat may be sent straight after reset.
// ----------------------------------------------------------------------------
module stream_id_range_bound_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_char_byte,
  input  logic                              in_last_char,
  input  logic                              in_bound_is_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sirb_pkg::VALUE_W-1:0]      out_millis_value,
  output logic [sirb_pkg::VALUE_W-1:0]      out_sequence_value,
  output logic                              out_id_valid
);
  import sirb_pkg::*;

  logic          in_vld_r;
  logic [7:0]    char_r;
  logic          last_r;
  logic          start_r;
  logic          advance;
  logic          out_vld_r;
  logic          out_vld_nxt;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t result_nxt;
  parse_result_t result_r;

  // The held beat moves on unless it is a last character blocked by a full,
  // stalled result register.
  assign advance  = in_vld_r && (!last_r || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r  <= in_char_byte;
      last_r  <= in_last_char;
      start_r <= in_bound_is_start;
    end
  end

  // Step logic.
  sirb_step u_step (
    .state_cur      (state_r),
    .char_byte      (char_r),
    .last_char      (last_r),
    .bound_is_start (start_r),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (advance && last_r) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_millis_value   = result_r.millis_value;
  assign out_sequence_value = result_r.sequence_value;
  assign out_id_valid       = result_r.id_valid;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !(advance && last_r))
    else $error("result register overwritten while stalled");

  // The parser state is cleared after each last character.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_r) |=> (state_r.chars_seen == 2'd0) && !state_r.after_dash)
    else $error("parser state not cleared after last character");

  // An invalid identifier carries zero values.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_id_valid) |->
      (out_millis_value == '0) && (out_sequence_value == '0))
    else $error("invalid result with non-zero values");

  // The character count saturates at two.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.chars_seen != 2'd3)
    else $error("character count past saturation");

  // A beat that is not the last character is never held back.
  a_nonlast_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !last_r) |-> advance)
    else $error("non-last character stalled");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for stream_id_range_bound_parser
// Feeds range-bound identifiers one character per beat, directed corner
// cases first and then random well formed and malformed identifiers. A
// parser model predicts each result beat, which is checked field by field
// against the output channel. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import sirb_pkg::*;

  localparam int CHAR_TARGET   = 1800;
  localparam int DRAIN_EVERY   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  // One character beat waiting to be sent; hold_first waits for an empty
  // result store before the beat is presented.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bound_start;
    logic       hold_first;
  } char_beat_t;

  // Receiver behaviour, changed at random intervals.
  typedef enum logic [1:0] {
    RX_READY,
    RX_SPARSE,
    RX_HEAVY,
    RX_BLOCKED
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_char_byte = 8'd0;
  logic                in_last_char = 1'b0;
  logic                in_bound_is_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  out_millis_value;
  logic [VALUE_W-1:0]  out_sequence_value;
  logic                out_id_valid;

  char_beat_t          char_beats[$];
  parse_result_t       ids_due[$];
  logic [7:0]          id_text[$];

  // Parser model state.
  logic                pm_after_dash;
  logic [VALUE_W-1:0]  pm_millis;
  logic [VALUE_W-1:0]  pm_sequence;
  logic                pm_bad;
  char_class_t         pm_first;
  logic [1:0]          pm_count;
  logic                pm_seq_digit;

  int                  error_count = 0;
  int                  chars_sent = 0;
  int                  ids_checked = 0;
  int                  ids_good = 0;
  int                  ids_rejected = 0;
  int                  burst_left = 1;
  int                  gap_left = 0;
  int                  stall_left = 0;
  int                  idle_cycles = 0;
  rx_mode_t            rx_mode = RX_READY;
  char_beat_t          next_beat;
  parse_result_t       want;

  stream_id_range_bound_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_byte       (in_char_byte),
    .in_last_char       (in_last_char),
    .in_bound_is_start  (in_bound_is_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_millis_value   (out_millis_value),
    .out_sequence_value (out_sequence_value),
    .out_id_valid       (out_id_valid)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic clear_parser();
    pm_after_dash = 1'b0;
    pm_millis     = '0;
    pm_sequence   = '0;
    pm_bad        = 1'b0;
    pm_first      = CLS_OTHER;
    pm_count      = 2'd0;
    pm_seq_digit  = 1'b0;
  endtask

  // Fold one accepted character into the model; on the last character the
  // parsed identifier is queued as the next expected result beat.
  task automatic parse_char(input logic [7:0] ch, input logic last, input logic bound_start);
    parse_result_t      res;
    logic [VALUE_W-1:0] digit;
    digit = VALUE_W'(ch - CHAR_ZERO);
    if (pm_count == 2'd0) begin
      pm_first = (ch == CHAR_DASH) ? CLS_DASH : (ch == CHAR_PLUS) ? CLS_PLUS : CLS_OTHER;
    end
    if (ch == CHAR_DASH) begin
      if (pm_after_dash || pm_count == 2'd0) pm_bad = 1'b1;
      pm_after_dash = 1'b1;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      if (pm_after_dash) begin
        pm_sequence  = pm_sequence * 64'd10 + digit;
        pm_seq_digit = 1'b1;
      end else begin
        pm_millis = pm_millis * 64'd10 + digit;
      end
    end else begin
      pm_bad = 1'b1;
    end
    if (pm_count != CHARS_MANY) pm_count++;
    if (last) begin
      res.millis_value   = '0;
      res.sequence_value = '0;
      if (pm_count == 2'd1 && pm_first == CLS_DASH) begin
        res.id_valid = bound_start;
      end else if (pm_count == 2'd1 && pm_first == CLS_PLUS) begin
        res.id_valid = !bound_start;
        if (!bound_start) begin
          res.millis_value   = VALUE_MAX;
          res.sequence_value = VALUE_MAX;
        end
      end else if (pm_bad) begin
        res.id_valid = 1'b0;
      end else if (pm_after_dash) begin
        res.id_valid = pm_seq_digit;
        if (pm_seq_digit) begin
          res.millis_value   = pm_millis;
          res.sequence_value = pm_sequence;
        end
      end else begin
        res.id_valid       = 1'b1;
        res.millis_value   = pm_millis;
        res.sequence_value = bound_start ? '0 : VALUE_MAX;
      end
      ids_due.push_back(res);
      clear_parser();
    end
  endtask

  // Identifier text building.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) id_text.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    logic all_nines;
    all_nines = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      id_text.push_back(all_nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  function automatic int digit_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 19);
    return $urandom_range(20, 24);
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_DASH);
    return b;
  endfunction

  // Turn the built text into beats; the bound flag matters on the last one
  // only, so the others carry a random flag.
  task automatic commit_id(input logic bound_start, input logic hold);
    char_beat_t b;
    for (int i = 0; i < id_text.size(); i++) begin
      b.ch          = id_text[i];
      b.last        = (i == id_text.size() - 1);
      b.bound_start = b.last ? bound_start : 1'($urandom_range(0, 1));
      b.hold_first  = hold && (i == 0);
      char_beats.push_back(b);
    end
    id_text.delete();
  endtask

  task automatic add_random_id(input logic hold);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // Well formed millis-sequence pair.
      add_digits(digit_run());
      id_text.push_back(CHAR_DASH);
      add_digits(digit_run());
    end else if (kind < 60) begin
      add_digits(digit_run());
    end else if (kind < 65) begin
      id_text.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_PLUS);
    end else if (kind < 70) begin
      // Leading dash, sometimes with a second part.
      id_text.push_back(CHAR_DASH);
      add_digits(digit_run());
      if ($urandom_range(0, 1)) begin
        id_text.push_back(CHAR_DASH);
        add_digits(digit_run());
      end
    end else if (kind < 75) begin
      add_digits(digit_run());
      id_text.push_back(CHAR_DASH);
    end else if (kind < 80) begin
      add_digits(digit_run());
      id_text.push_back(CHAR_DASH);
      add_digits(digit_run());
      id_text.push_back(CHAR_DASH);
      if ($urandom_range(0, 1)) add_digits($urandom_range(1, 4));
    end else if (kind < 90) begin
      // Well formed pair with one stray byte somewhere in it.
      add_digits(digit_run());
      id_text.push_back(CHAR_DASH);
      add_digits(digit_run());
      id_text.insert($urandom_range(0, id_text.size()), non_digit());
    end else if (kind < 95) begin
      if ($urandom_range(0, 1)) begin
        id_text.push_back(CHAR_PLUS);
        add_digits($urandom_range(1, 5));
      end else begin
        add_digits($urandom_range(1, 5));
        id_text.push_back(CHAR_PLUS);
        add_digits($urandom_range(0, 3));
      end
    end else begin
      repeat ($urandom_range(1, 4)) id_text.push_back(8'($urandom_range(0, 255)));
    end
    commit_id(1'($urandom_range(0, 1)), hold);
  endtask

  // Sender: bursts of beats with random gaps; the model is updated on each
  // accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(in_char_byte, in_last_char, in_bound_is_start);
        chars_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_beats.size() != 0 &&
                     !(char_beats[0].hold_first && ids_due.size() != 0)) begin
          next_beat = char_beats.pop_front();
          in_valid          <= 1'b1;
          in_char_byte      <= next_beat.ch;
          in_last_char      <= next_beat.last;
          in_bound_is_start <= next_beat.bound_start;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 9) == 0) begin
              burst_left = $urandom_range(100, 200);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern plus the result check.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        ids_checked++;
        if (ids_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d-%0d valid %0b",
                                    out_millis_value, out_sequence_value, out_id_valid));
        end else begin
          want = ids_due.pop_front();
          if (out_millis_value !== want.millis_value)
            report_mismatch($sformatf("millis %0d, expected %0d",
                                      out_millis_value, want.millis_value));
          if (out_sequence_value !== want.sequence_value)
            report_mismatch($sformatf("sequence %0d, expected %0d",
                                      out_sequence_value, want.sequence_value));
          if (out_id_valid !== want.id_valid)
            report_mismatch($sformatf("id_valid %0b, expected %0b",
                                      out_id_valid, want.id_valid));
          if (want.id_valid) ids_good++;
          else ids_rejected++;
        end
      end
      if (stall_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        stall_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 30) : $urandom_range(4, 60);
      end else begin
        stall_left--;
      end
      case (rx_mode)
        RX_READY:  out_stall <= 1'b0;
        RX_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        RX_HEAVY:  out_stall <= ($urandom_range(0, 7) != 0);
        default:   out_stall <= 1'b1;
      endcase
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, ids_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int directed;
    int drain_marks;
    clear_parser();

    // Directed cases: lone dash and lone plus for both bound kinds, digits
    // only for both kinds, a plain pair, leading, trailing and second dash,
    // a letter, and the lowest and highest byte values.
    add_text("-");     commit_id(1'b1, 1'b0);
    add_text("-");     commit_id(1'b0, 1'b0);
    add_text("+");     commit_id(1'b0, 1'b0);
    add_text("+");     commit_id(1'b1, 1'b0);
    add_text("5");     commit_id(1'b1, 1'b0);
    add_text("7");     commit_id(1'b0, 1'b0);
    add_text("1-2");   commit_id(1'b1, 1'b0);
    add_text("-5");    commit_id(1'b1, 1'b0);
    add_text("5-");    commit_id(1'b0, 1'b0);
    add_text("1-2-3"); commit_id(1'b1, 1'b0);
    add_text("a");     commit_id(1'b0, 1'b0);
    id_text.push_back(8'h00); commit_id(1'b1, 1'b0);
    id_text.push_back(8'hFF); commit_id(1'b0, 1'b0);
    directed = char_beats.size();

    // Random identifiers; each time another block of characters has been
    // queued the sender waits for the output side to empty first.
    drain_marks = -1;
    while (char_beats.size() < directed + CHAR_TARGET) begin
      add_random_id((char_beats.size() - directed) / DRAIN_EVERY != drain_marks);
      drain_marks = (char_beats.size() - directed) / DRAIN_EVERY;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (char_beats.size() != 0 || in_valid || ids_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ids_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", ids_due.size()));

    $display("Sent %0d characters; checked %0d identifiers (%0d accepted, %0d rejected).",
             chars_sent, ids_checked, ids_good, ids_rejected);
    $display("Mix: lone bounds, digit-only ids, pairs with 64-bit wrap, malformed ids, noise.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
